@@ sv/rtn_pkg.sv @@
// Shared constants, types and helpers for the RGB to NV12 converter.
package rtn_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  localparam int QUAD_W     = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [QUAD_W-1:0] WIDTH_LIMIT  = QUAD_W'(MAX_WIDTH / 4);
  localparam logic [QUAD_W-1:0] HEIGHT_LIMIT = QUAD_W'(MAX_HEIGHT / 4);
  localparam logic [QUAD_W-1:0] WIDTH_RESET  = QUAD_W'(160);
  localparam logic [QUAD_W-1:0] HEIGHT_RESET = QUAD_W'(120);

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_QUADS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_QUADS = CFG_IDX_W'(1);

  localparam logic [23:0] Y_R   = 24'd16843;
  localparam logic [23:0] Y_G   = 24'd33030;
  localparam logic [23:0] Y_B   = 24'd6423;
  localparam logic [23:0] Y_OFS = 24'd1048576;
  localparam logic [23:0] U_R   = 24'd9699;
  localparam logic [23:0] U_G   = 24'd19071;
  localparam logic [23:0] U_B   = 24'd28770;
  localparam logic [23:0] V_R   = 24'd28770;
  localparam logic [23:0] V_G   = 24'd24117;
  localparam logic [23:0] V_B   = 24'd4653;
  localparam logic [23:0] C_OFS = 24'd8388608;

  typedef struct packed {
    logic               odd_col;
    logic               odd_row;
    logic               frame_last;
    logic [LINE_AW-1:0] idx;
  } pos_t;

  function automatic logic [QUAD_W-1:0] clamp_quads(input logic [QUAD_W-1:0] q,
                                                    input logic [QUAD_W-1:0] limit);
    logic [QUAD_W-1:0] res;
    if (q == '0) begin
      res = QUAD_W'(1);
    end else if (q > limit) begin
      res = limit;
    end else begin
      res = q;
    end
    return res;
  endfunction

endpackage

@@ sv/rtn_pos.sv @@
// Frame geometry registers and raster position counters.
module rtn_pos import rtn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QUAD_W-1:0]    cfg_wdata,
  input  logic                 advance,
  output pos_t                 pos
);

  logic [QUAD_W-1:0] width_quads_r, width_quads_nxt;
  logic [QUAD_W-1:0] height_quads_r, height_quads_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [QUAD_W-1:0] width_eff, height_eff;
  logic [COL_W:0]    col_last;
  logic [ROW_W:0]    row_last;
  logic              last_col, last_row;

  always_comb begin
    width_eff  = clamp_quads(width_quads_r, WIDTH_LIMIT);
    height_eff = clamp_quads(height_quads_r, HEIGHT_LIMIT);
    col_last   = (COL_W+1)'({width_eff, 2'b00}) - (COL_W+1)'(1);
    row_last   = (ROW_W+1)'({height_eff, 2'b00}) - (ROW_W+1)'(1);
    last_col   = (col_r == col_last[COL_W-1:0]);
    last_row   = (row_r == row_last[ROW_W-1:0]);

    pos.odd_col    = col_r[0];
    pos.odd_row    = row_r[0];
    pos.frame_last = last_col && last_row;
    pos.idx        = col_r[COL_W-1:1];
  end

  always_comb begin
    width_quads_nxt  = width_quads_r;
    height_quads_nxt = height_quads_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_QUADS:  width_quads_nxt  = cfg_wdata;
        CFG_HEIGHT_QUADS: height_quads_nxt = cfg_wdata;
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (advance) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_quads_r  <= WIDTH_RESET;
      height_quads_r <= HEIGHT_RESET;
      col_r          <= '0;
      row_r          <= '0;
    end else begin
      width_quads_r  <= width_quads_nxt;
      height_quads_r <= height_quads_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
    end
  end

endmodule

@@ sv/rtn_csc.sv @@
// BT.601 color space conversion of one pixel to 8-bit Y, U and V.
module rtn_csc import rtn_pkg::*; (
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  output logic [7:0] y,
  output logic [7:0] u,
  output logic [7:0] v
);

  logic [23:0] r24, g24, b24;
  logic [23:0] y_acc, u_acc, v_acc;

  always_comb begin
    r24   = 24'(red);
    g24   = 24'(green);
    b24   = 24'(blue);
    y_acc = Y_OFS + Y_R * r24 + Y_G * g24 + Y_B * b24;
    u_acc = C_OFS + U_B * b24 - U_R * r24 - U_G * g24;
    v_acc = C_OFS + V_R * r24 - V_G * g24 - V_B * b24;
    y     = y_acc[23:16];
    u     = u_acc[23:16];
    v     = v_acc[23:16];
  end

endmodule

@@ sv/rgb_to_nv12_converter.sv @@
// Top level: RGB pixel stream to NV12 luma words and 2x2 chroma words.
// A pixel is registered in s1, then its luma word in the output register.
// Throughput: one pixel per cycle unless out_ready stalls; an odd-column pixel of
// an odd row blocks the next; its luma and chroma words use one output register.
// Reset (rst_n low, synchronous): counters and handshake state clear, size
// registers return to 160 and 120 quads; the pair-sum line buffer is not cleared.
module rgb_to_nv12_converter import rtn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QUAD_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_blue,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_red,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_chroma,
  output logic [7:0]           out_first_sample,
  output logic [7:0]           out_second_sample,
  output logic                 out_last_of_item,
  output logic                 out_frame_end
);

  pos_t        pos;
  logic        accept;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_blue_r, s1_green_r, s1_red_r;
  pos_t        s1_pos_r;
  logic        phase_r, phase_nxt;
  logic [17:0] rd_data_r;
  logic [7:0]  held_u_r, held_v_r;

  logic [17:0] line_mem [LINE_DEPTH];

  logic [7:0]  y, u, v;
  logic        out_load, emit, needs_chroma, done;
  logic        mem_we;
  logic [8:0]  pair_u, pair_v;
  logic [9:0]  quad_u, quad_v;

  logic        out_valid_r, out_valid_nxt;
  logic        out_is_chroma_r, out_last_r, out_fend_r;
  logic [7:0]  out_first_r, out_second_r;

  rtn_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (accept),
    .pos       (pos)
  );

  rtn_csc u_csc (
    .blue  (s1_blue_r),
    .green (s1_green_r),
    .red   (s1_red_r),
    .y     (y),
    .u     (u),
    .v     (v)
  );

  always_comb begin
    out_load     = !out_valid_r || out_ready;
    emit         = s1_valid_r && out_load;
    needs_chroma = s1_pos_r.odd_col && s1_pos_r.odd_row;
    done         = emit && (phase_r || !needs_chroma);
    in_ready     = !s1_valid_r || done;
    accept       = in_valid && in_ready;

    s1_valid_nxt = accept ? 1'b1 : (done ? 1'b0 : s1_valid_r);
    phase_nxt    = done ? 1'b0 : ((emit && needs_chroma) ? 1'b1 : phase_r);
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;

    mem_we = emit && !phase_r && s1_pos_r.odd_col && !s1_pos_r.odd_row;
    pair_u = 9'(held_u_r) + 9'(u);
    pair_v = 9'(held_v_r) + 9'(v);
    quad_u = 10'(rd_data_r[17:9]) + 10'(held_u_r) + 10'(u);
    quad_v = 10'(rd_data_r[8:0]) + 10'(held_v_r) + 10'(v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      held_u_r    <= '0;
      held_v_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (emit && !phase_r && !s1_pos_r.odd_col) begin
        held_u_r <= u;
        held_v_r <= v;
      end
    end
  end

  // hold the accepted pixel and its position
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_blue_r  <= in_blue;
      s1_green_r <= in_green;
      s1_red_r   <= in_red;
      s1_pos_r   <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_pos_r.idx] <= {pair_u, pair_v};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= line_mem[pos.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (phase_r) begin
        out_is_chroma_r <= 1'b1;
        out_first_r     <= quad_u[9:2];
        out_second_r    <= quad_v[9:2];
        out_last_r      <= 1'b1;
        out_fend_r      <= s1_pos_r.frame_last;
      end else begin
        out_is_chroma_r <= 1'b0;
        out_first_r     <= y;
        out_second_r    <= '0;
        out_last_r      <= !needs_chroma;
        out_fend_r      <= !needs_chroma && s1_pos_r.frame_last;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_chroma     = out_is_chroma_r;
  assign out_first_sample  = out_first_r;
  assign out_second_sample = out_second_r;
  assign out_last_of_item  = out_last_r;
  assign out_frame_end     = out_fend_r;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the RGB to NV12 converter: directed table, then random frames.
module tb;
  import rtn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CYCLE_LIMIT  = 2_000_000;
  localparam int  DRAIN_CYCLES = 4;
  localparam int  ITEM_GOAL    = 1500;
  localparam int  SHOW_LIMIT   = 40;
  localparam bit  ROW_PIX      = 1'b0;
  localparam bit  ROW_CFG      = 1'b1;

  typedef struct packed {
    logic       is_chroma;
    logic [7:0] first_sample;
    logic [7:0] second_sample;
    logic       last_of_item;
    logic       frame_end;
  } nv12_word_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [QUAD_W-1:0]    data;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
    logic                 has_y;
    logic [7:0]           y;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [QUAD_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_blue = '0;
  logic [7:0]           in_green = '0;
  logic [7:0]           in_red = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_is_chroma;
  logic [7:0]           out_first_sample;
  logic [7:0]           out_second_sample;
  logic                 out_last_of_item;
  logic                 out_frame_end;

  nv12_word_t           expected_words[$];
  int                   mismatches = 0;
  int                   pixels_sent = 0;
  int                   cycle_count = 0;
  int                   ready_stall = 0;
  bit                   quiet = 1'b0;

  logic [QUAD_W-1:0]    width_q;
  logic [QUAD_W-1:0]    height_q;
  int unsigned          col_pos;
  int unsigned          row_pos;
  logic [7:0]           held_u;
  logic [7:0]           held_v;
  logic [17:0]          pair_sums [LINE_DEPTH];

  stim_row_t            directed_rows [25];

  rgb_to_nv12_converter i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_blue           (in_blue),
    .in_green          (in_green),
    .in_red            (in_red),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_chroma     (out_is_chroma),
    .out_first_sample  (out_first_sample),
    .out_second_sample (out_second_sample),
    .out_last_of_item  (out_last_of_item),
    .out_frame_end     (out_frame_end)
  );

  always #10 clk = ~clk;

  function automatic int unsigned frame_dim(input logic [QUAD_W-1:0] q,
                                            input logic [QUAD_W-1:0] limit);
    int unsigned quads;
    quads = (q == '0) ? 1 : ((q > limit) ? int'(limit) : int'(q));
    return quads * 4;
  endfunction

  function automatic void predict_pixel(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r, input logic has_y,
                                        input logic [7:0] y_typed);
    int unsigned w, h, idx;
    int          y_sum, u_sum, v_sum, su, sv;
    logic [7:0]  y, u, v;
    logic        fend;
    nv12_word_t  luma, chroma;
    w = frame_dim(width_q, WIDTH_LIMIT);
    h = frame_dim(height_q, HEIGHT_LIMIT);
    y_sum = 16843 * int'(r) + 33030 * int'(g) + 6423 * int'(b) + 1048576;
    u_sum = 8388608 + 28770 * int'(b) - 9699 * int'(r) - 19071 * int'(g);
    v_sum = 8388608 + 28770 * int'(r) - 24117 * int'(g) - 4653 * int'(b);
    y = 8'(y_sum >> 16);
    u = 8'(u_sum >> 16);
    v = 8'(v_sum >> 16);
    fend = (col_pos == w - 1) && (row_pos == h - 1);
    idx = (col_pos >> 1) & (LINE_DEPTH - 1);
    luma = '{1'b0, has_y ? y_typed : y, 8'd0, 1'b1, fend};
    if (!col_pos[0]) begin
      held_u = u;
      held_v = v;
      expected_words.push_back(luma);
    end else if (!row_pos[0]) begin
      pair_sums[idx] = {9'(held_u) + 9'(u), 9'(held_v) + 9'(v)};
      expected_words.push_back(luma);
    end else begin
      su = int'(pair_sums[idx][17:9]) + int'(held_u) + int'(u);
      sv = int'(pair_sums[idx][8:0]) + int'(held_v) + int'(v);
      luma.last_of_item = 1'b0;
      luma.frame_end = 1'b0;
      chroma = '{1'b1, 8'(su >> 2), 8'(sv >> 2), 1'b1, fend};
      expected_words.push_back(luma);
      expected_words.push_back(chroma);
    end
    if (col_pos == w - 1) begin
      col_pos = 0;
      row_pos = (row_pos == h - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [QUAD_W-1:0] pick_quads(input logic [QUAD_W-1:0] dflt);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return QUAD_W'(1);
    if (r < 45) return '0;
    if (r < 75) return QUAD_W'($urandom_range(2, 4));
    if (r < 85) return QUAD_W'($urandom_range(5, 16));
    if (r < 90) return WIDTH_LIMIT;
    if (r < 94) return QUAD_W'($urandom_range(1025, 2047));
    if (r < 97) return dflt;
    return QUAD_W'($urandom_range(17, 1023));
  endfunction

  // hold the sender until every expected word is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [QUAD_W-1:0] data);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_WIDTH_QUADS) width_q = data;
    else height_q = data;
    col_pos = 0;
    row_pos = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic has_y, input logic [7:0] y_typed);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    do @(posedge clk); while (!in_ready);
    predict_pixel(b, g, r, has_y, y_typed);
    pixels_sent++;
  endtask

  task automatic run_phase(input bit force_pause);
    int kind, n, frame_px, pause_at;
    kind = $urandom_range(0, 3);
    if (kind != 1) write_reg(CFG_WIDTH_QUADS, pick_quads(WIDTH_RESET));
    if (kind != 0) write_reg(CFG_HEIGHT_QUADS, pick_quads(HEIGHT_RESET));
    frame_px = frame_dim(width_q, WIDTH_LIMIT) * frame_dim(height_q, HEIGHT_LIMIT);
    if (frame_px <= 400) begin
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 2 * frame_px);
      else n = frame_px * $urandom_range(1, 3);
    end else begin
      n = $urandom_range(50, 250);
    end
    if (n > ITEM_GOAL - pixels_sent) n = ITEM_GOAL - pixels_sent;
    if (n < 1) n = 1;
    pause_at = (force_pause || $urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) wait_drained();
      push_pixel(pick_level(), pick_level(), pick_level(), 1'b0, 8'd0);
    end
  endtask

  always @(negedge clk) begin
    if (ready_stall > 0) begin
      out_ready   <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      out_ready   <= 1'b1;
      ready_stall <= pick_gap();
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(200, 800)) @(posedge clk);
      quiet = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    nv12_word_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_is_chroma, out_first_sample, out_second_sample, out_last_of_item,
              out_frame_end};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: unexpected word chroma=%0d first=%0d second=%0d last=%0d fend=%0d",
                   $realtime, got.is_chroma, got.first_sample, got.second_sample,
                   got.last_of_item, got.frame_end);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     $realtime, want.is_chroma, want.first_sample, want.second_sample,
                     want.last_of_item, want.frame_end, got.is_chroma, got.first_sample,
                     got.second_sample, got.last_of_item, got.frame_end);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    directed_rows = '{
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd16},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd235},
      '{ROW_CFG, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_CFG, CFG_HEIGHT_QUADS, 11'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd16},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd235},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd0,   8'd255, 1'b1, 8'd81},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd255, 8'd0,   1'b1, 8'd144},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd255, 8'd0,   8'd0,   1'b1, 8'd40},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd255, 8'd255, 8'd0,   1'b0, 8'd0},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd255, 8'd255, 1'b0, 8'd0},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd255, 8'd0,   8'd255, 1'b0, 8'd0},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd1,   8'd2,   8'd3,   1'b0, 8'd0},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd128, 8'd128, 8'd128, 1'b0, 8'd0},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd254, 8'd1,   8'd127, 1'b0, 8'd0},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd0,   8'd1,   1'b0, 8'd0},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd235},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd235},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd16},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd16},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd16},
      '{ROW_CFG, CFG_WIDTH_QUADS,  11'd2047, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd235},
      '{ROW_CFG, CFG_HEIGHT_QUADS, 11'd1024, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIX, CFG_WIDTH_QUADS,  11'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd16}
    };
    width_q  = WIDTH_RESET;
    height_q = HEIGHT_RESET;
    col_pos  = 0;
    row_pos  = 0;
    held_u   = '0;
    held_v   = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg == ROW_CFG)
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        push_pixel(directed_rows[i].blue, directed_rows[i].green, directed_rows[i].red,
                   directed_rows[i].has_y, directed_rows[i].y);
    end

    run_phase(1'b1);
    while (pixels_sent < ITEM_GOAL) run_phase(1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rtn_pkg.sv
sv/rtn_pos.sv
sv/rtn_csc.sv
sv/rgb_to_nv12_converter.sv
tb/tb.sv
